/* rtl/core/ostp_pkg.sv */
// Package with shared types and codes for the one-shot timer pool.
`default_nettype none
package ostp_pkg;
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_TICK    = 2'd1,
        OP_RECOUNT = 2'd2,
        OP_FREE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EXPIRED    = 3'd1,
        ST_NO_EXPIRY  = 3'd2,
        ST_NO_SLOT    = 3'd3,
        ST_NOT_COUNT  = 3'd4,
        ST_NOT_FIRED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MODE_FREE     = 2'd0,
        MODE_COUNTING = 2'd1,
        MODE_FIRED    = 2'd2
    } mode_t;

    localparam int SLOT_FIELD_BITS = 4;
    localparam int OP_BITS         = 2;
    localparam int STATUS_BITS     = 3;
endpackage
`default_nettype wire

/* rtl/core/one_shot_timer_pool_unit.sv */
// Top level of the one-shot timer pool: cell row, free stack and control.
// Usage:
//   s_axis carries one command word: operation, slot, count, tag.
//   m_axis returns result words: status, slot, tag, with tlast on the
//   final word of each command.
//   Allocate, recount and free give one word, valid the cycle after accept.
//   A tick walks the active timers newest first, one timer per cycle
//   while the output register is not stalled, and yields one word per
//   expired timer (or one "no expiry" word). The walk runs over an age
//   rank held in each cell; the rank of a cell equals its position in
//   the active list, and older cells close up by one rank as soon as a
//   newer one expires.
//   One command is in work at a time; s_tready is low until its last
//   word has left the output register.
//   Reset frees every slot; slots are then handed out 0 to SLOTS-1 and
//   the last freed slot is reused first.
//   A stalled receiver holds the output register and pauses the walk.
`default_nettype none
module one_shot_timer_pool_unit #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16,
    parameter int TAG_BITS   = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation[1:0], slot[5:2], count[21:6], tag[53:22], zero fill
    input  wire logic [((22+TAG_BITS+COUNT_BITS-16)+7)/8*8-1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], slot_out[6:3], tag_out[38:7], zero fill
    output logic [((7+TAG_BITS)+7)/8*8-1:0] m_tdata,
    output logic             m_tlast
);
    localparam int IDX_BITS  = $clog2(SLOTS);
    localparam int RANK_BITS = $clog2(SLOTS + 1);
    localparam int CNT_LO    = 6;
    localparam int TAG_LO    = CNT_LO + COUNT_BITS;
    localparam int M_BITS    = ((7+TAG_BITS)+7)/8*8;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]            op;
    logic [3:0]            slot_f;
    logic [COUNT_BITS-1:0] count_f;
    logic [TAG_BITS-1:0]   tag_f;
    assign op      = s_tdata[1:0];
    assign slot_f  = s_tdata[5:2];
    assign count_f = s_tdata[TAG_LO-1:CNT_LO];
    assign tag_f   = s_tdata[TAG_LO+TAG_BITS-1:TAG_LO];

    // free stack in a small register file
    logic [IDX_BITS-1:0] fstack_reg [SLOTS];
    logic [RANK_BITS-1:0] fsp_reg, fsp_next;
    logic [RANK_BITS-1:0] nact_reg, nact_next;

    ostp_pkg::mode_t      mode_w  [SLOTS];
    logic [RANK_BITS-1:0] rank_w  [SLOTS];
    logic [TAG_BITS-1:0]  tag_w   [SLOTS];
    logic [SLOTS-1:0]     exp_w;
    logic [SLOTS-1:0]     load_v, reload_v, free_v, step_v, bump_v, drop_v;

    logic [RANK_BITS-1:0] walk_reg, walk_next;
    logic                 any_reg, any_next;
    logic [IDX_BITS-1:0]  hit_idx;
    logic                 hit_any;
    logic                 hit_exp;
    logic                 later_exp;

    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_status_reg, out_status_next;
    logic [3:0]           out_slot_reg, out_slot_next;
    logic [TAG_BITS-1:0]  out_tag_reg, out_tag_next;
    logic                 out_last_reg, out_last_next;

    logic                 accept;
    logic                 slot_ok;
    logic [IDX_BITS-1:0]  slot_idx;
    logic [IDX_BITS-1:0]  alloc_idx;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign slot_ok   = 32'(slot_f) < SLOTS;
    assign slot_idx  = IDX_BITS'(slot_f);
    assign alloc_idx = fstack_reg[fsp_reg[IDX_BITS-1:0]];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            ostp_cell #(
                .COUNT_BITS(COUNT_BITS),
                .TAG_BITS  (TAG_BITS),
                .RANK_BITS (RANK_BITS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .load     (load_v[g]),
                .reload   (reload_v[g]),
                .make_free(free_v[g]),
                .tick_step(step_v[g]),
                .rank_bump(bump_v[g]),
                .rank_drop(drop_v[g]),
                .count_in (count_f),
                .tag_in   (tag_f),
                .mode     (mode_w[g]),
                .rank     (rank_w[g]),
                .tag      (tag_w[g]),
                .expiring (exp_w[g])
            );
        end
    endgenerate

    // find the active cell at the current walk rank
    always_comb begin
        hit_idx   = '0;
        hit_any   = 1'b0;
        later_exp = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (mode_w[i] == ostp_pkg::MODE_COUNTING && rank_w[i] == walk_reg) begin
                hit_idx = IDX_BITS'(i);
                hit_any = 1'b1;
            end
            if (exp_w[i] && rank_w[i] > walk_reg) begin
                later_exp = 1'b1;
            end
        end
        hit_exp = hit_any && exp_w[hit_idx];
    end

    always_comb begin
        state_next      = state_reg;
        fsp_next        = fsp_reg;
        nact_next       = nact_reg;
        walk_next       = walk_reg;
        any_next        = any_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        load_v   = '0;
        reload_v = '0;
        free_v   = '0;
        step_v   = '0;
        bump_v   = '0;
        drop_v   = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_valid_next = 1'b1;
                    out_tag_next   = '0;
                    out_last_next  = 1'b1;
                    out_slot_next  = slot_f;
                    out_status_next = ostp_pkg::ST_OK;
                    unique case (ostp_pkg::op_t'(op))
                        ostp_pkg::OP_ALLOC: begin
                            if (fsp_reg == RANK_BITS'(SLOTS)) begin
                                out_status_next = ostp_pkg::ST_NO_SLOT;
                                out_slot_next   = '0;
                            end else begin
                                load_v[alloc_idx] = 1'b1;
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (mode_w[i] == ostp_pkg::MODE_COUNTING) begin
                                        bump_v[i] = 1'b1;
                                    end
                                end
                                fsp_next      = fsp_reg + RANK_BITS'(1);
                                nact_next     = nact_reg + RANK_BITS'(1);
                                out_slot_next = 4'(alloc_idx);
                            end
                        end
                        ostp_pkg::OP_TICK: begin
                            out_valid_next = 1'b0;
                            walk_next      = '0;
                            any_next       = 1'b0;
                            state_next     = S_WALK;
                        end
                        ostp_pkg::OP_RECOUNT: begin
                            if (!slot_ok ||
                                mode_w[slot_idx] != ostp_pkg::MODE_COUNTING) begin
                                out_status_next = ostp_pkg::ST_NOT_COUNT;
                            end else begin
                                reload_v[slot_idx] = 1'b1;
                            end
                        end
                        ostp_pkg::OP_FREE: begin
                            if (!slot_ok ||
                                mode_w[slot_idx] != ostp_pkg::MODE_FIRED) begin
                                out_status_next = ostp_pkg::ST_NOT_FIRED;
                            end else begin
                                free_v[slot_idx] = 1'b1;
                                fsp_next = fsp_reg - RANK_BITS'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (walk_reg >= nact_reg) begin
                    state_next = S_DONE;
                end else if (!out_valid_reg || m_tready) begin
                    step_v[hit_idx] = hit_any;
                    if (hit_exp) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ostp_pkg::ST_EXPIRED;
                        out_slot_next   = 4'(hit_idx);
                        out_tag_next    = tag_w[hit_idx];
                        out_last_next   = !later_exp;
                        nact_next       = nact_reg - RANK_BITS'(1);
                        any_next        = 1'b1;
                        // older cells close up behind the removed one
                        for (int i = 0; i < SLOTS; i++) begin
                            if (mode_w[i] == ostp_pkg::MODE_COUNTING &&
                                rank_w[i] > walk_reg) begin
                                drop_v[i] = 1'b1;
                            end
                        end
                    end else begin
                        walk_next = walk_reg + RANK_BITS'(1);
                    end
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    if (!any_reg) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ostp_pkg::ST_NO_EXPIRY;
                        out_slot_next   = '0;
                        out_tag_next    = '0;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fsp_reg       <= '0;
            nact_reg      <= '0;
            out_valid_reg <= 1'b0;
            walk_reg      <= '0;
            any_reg       <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                fstack_reg[i] <= IDX_BITS'(i);
            end
        end else begin
            state_reg     <= state_next;
            fsp_reg       <= fsp_next;
            nact_reg      <= nact_next;
            out_valid_reg <= out_valid_next;
            walk_reg      <= walk_next;
            any_reg       <= any_next;
            if (state_reg == S_IDLE && accept && op == ostp_pkg::OP_FREE &&
                free_v[slot_idx]) begin
                fstack_reg[fsp_next[IDX_BITS-1:0]] <= slot_idx;
            end
        end
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_tag_reg    <= out_tag_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_BITS'({out_tag_reg, out_slot_reg, out_status_reg});

    property p_ready_idle;
        @(posedge aclk) disable iff (!aresetn) s_tready |-> state_reg == S_IDLE;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

    property p_fsp_range;
        @(posedge aclk) disable iff (!aresetn) fsp_reg <= RANK_BITS'(SLOTS);
    endproperty
    a_fsp_range: assert property (p_fsp_range) else $error("free stack overflow");

    property p_nact_range;
        @(posedge aclk) disable iff (!aresetn) nact_reg <= RANK_BITS'(SLOTS);
    endproperty
    a_nact_range: assert property (p_nact_range) else $error("active count overflow");
endmodule
`default_nettype wire

/* rtl/core/ostp_cell.sv */
// One timer cell: mode, count, tag and age rank of a single slot.
`default_nettype none
module ostp_cell #(
    parameter int COUNT_BITS = 16,
    parameter int TAG_BITS   = 32,
    parameter int RANK_BITS  = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire logic                  reload,
    input  wire logic                  make_free,
    input  wire logic                  tick_step,
    input  wire logic                  rank_bump,
    input  wire logic                  rank_drop,
    input  wire logic [COUNT_BITS-1:0] count_in,
    input  wire logic [TAG_BITS-1:0]   tag_in,
    output ostp_pkg::mode_t            mode,
    output logic [RANK_BITS-1:0]       rank,
    output logic [TAG_BITS-1:0]        tag,
    output logic                       expiring
);
    ostp_pkg::mode_t         mode_reg, mode_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [TAG_BITS-1:0]     tag_reg, tag_next;
    logic [RANK_BITS-1:0]    rank_reg, rank_next;

    assign expiring = (mode_reg == ostp_pkg::MODE_COUNTING) &&
                      (count_reg <= COUNT_BITS'(1));

    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        tag_next   = tag_reg;
        rank_next  = rank_reg;
        if (load) begin
            mode_next  = ostp_pkg::MODE_COUNTING;
            count_next = count_in;
            tag_next   = tag_in;
            rank_next  = '0;
        end else if (reload) begin
            count_next = count_in;
        end else if (make_free) begin
            mode_next = ostp_pkg::MODE_FREE;
        end else if (tick_step) begin
            if (expiring) begin
                mode_next  = ostp_pkg::MODE_FIRED;
                count_next = '0;
            end else begin
                count_next = count_reg - COUNT_BITS'(1);
            end
        end
        if (rank_bump && !load) begin
            rank_next = rank_reg + RANK_BITS'(1);
        end else if (rank_drop && !load) begin
            rank_next = rank_reg - RANK_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ostp_pkg::MODE_FREE;
            rank_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            rank_reg <= rank_next;
        end
        count_reg <= count_next;
        tag_reg   <= tag_next;
    end

    assign mode = mode_reg;
    assign rank = rank_reg;
    assign tag  = tag_reg;
endmodule
`default_nettype wire

/* tb/tb_one_shot_timer_pool_unit.sv */
// Testbench for the one-shot timer pool: random and directed commands checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_one_shot_timer_pool_unit;
    localparam int N_SLOTS = 16;
    localparam int NONE_IDX = N_SLOTS;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0]      tag;
        logic [15:0]      count;
        logic [3:0]       slot;
        ostp_pkg::op_t    op;
    } cmd_t;

    typedef struct packed {
        ostp_pkg::status_t status;
        logic [3:0]        slot;
        logic [31:0]       tag;
        logic              last;
    } word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [55:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic m_tlast;
    logic in_fire = 1'b0;

    one_shot_timer_pool_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    ostp_pkg::mode_t pool_mode [N_SLOTS];
    logic [15:0]     pool_left [N_SLOTS];
    logic [31:0]     pool_tag  [N_SLOTS];
    int              pool_next [N_SLOTS];
    int              free_top;
    int              newest;

    cmd_t  cmd_queue [$];
    word_t result_queue [$];
    int    errors = 0;
    bit    sender_quiet = 1'b0;
    bit    recv_quiet = 1'b0;
    bit    hold_sender = 1'b0;
    int    cycles = 0;

    function automatic word_t mk(ostp_pkg::status_t st, int sl, logic [31:0] tg, bit lst);
        word_t w;
        w.status = st;
        w.slot = sl[3:0];
        w.tag = tg;
        w.last = lst;
        return w;
    endfunction

    task automatic pool_clear();
        for (int i = 0; i < N_SLOTS; i++) begin
            pool_mode[i] = ostp_pkg::MODE_FREE;
            pool_left[i] = '0;
            pool_tag[i] = '0;
            pool_next[i] = i + 1;
        end
        free_top = 0;
        newest = NONE_IDX;
    endtask

    task automatic pool_apply(cmd_t c);
        int s;
        int prev;
        int cur;
        int nxt;
        int fired;
        case (c.op)
            ostp_pkg::OP_ALLOC: begin
                s = free_top;
                if (s >= N_SLOTS) begin
                    result_queue.push_back(mk(ostp_pkg::ST_NO_SLOT, 0, '0, 1'b1));
                end else begin
                    free_top = pool_next[s];
                    pool_left[s] = c.count;
                    pool_tag[s] = c.tag;
                    pool_mode[s] = ostp_pkg::MODE_COUNTING;
                    pool_next[s] = newest;
                    newest = s;
                    result_queue.push_back(mk(ostp_pkg::ST_OK, s, '0, 1'b1));
                end
            end
            ostp_pkg::OP_TICK: begin
                prev = NONE_IDX;
                cur = newest;
                fired = 0;
                for (int g = 0; g < N_SLOTS && cur < N_SLOTS; g++) begin
                    nxt = pool_next[cur];
                    if (pool_left[cur] <= 16'd1) begin
                        pool_left[cur] = '0;
                        if (prev < N_SLOTS) pool_next[prev] = nxt;
                        else newest = nxt;
                        pool_next[cur] = NONE_IDX;
                        pool_mode[cur] = ostp_pkg::MODE_FIRED;
                        result_queue.push_back(mk(ostp_pkg::ST_EXPIRED, cur,
                                                  pool_tag[cur], 1'b0));
                        fired++;
                    end else begin
                        pool_left[cur] = pool_left[cur] - 16'd1;
                        prev = cur;
                    end
                    cur = nxt;
                end
                if (fired == 0) result_queue.push_back(mk(ostp_pkg::ST_NO_EXPIRY, 0, '0, 1'b1));
                else result_queue[$].last = 1'b1;
            end
            ostp_pkg::OP_RECOUNT: begin
                if (pool_mode[c.slot] != ostp_pkg::MODE_COUNTING) begin
                    result_queue.push_back(mk(ostp_pkg::ST_NOT_COUNT, c.slot, '0, 1'b1));
                end else begin
                    pool_left[c.slot] = c.count;
                    result_queue.push_back(mk(ostp_pkg::ST_OK, c.slot, '0, 1'b1));
                end
            end
            default: begin
                if (pool_mode[c.slot] != ostp_pkg::MODE_FIRED) begin
                    result_queue.push_back(mk(ostp_pkg::ST_NOT_FIRED, c.slot, '0, 1'b1));
                end else begin
                    pool_mode[c.slot] = ostp_pkg::MODE_FREE;
                    pool_next[c.slot] = free_top;
                    free_top = c.slot;
                    result_queue.push_back(mk(ostp_pkg::ST_OK, c.slot, '0, 1'b1));
                end
            end
        endcase
    endtask

    function automatic cmd_t mkcmd(ostp_pkg::op_t op, int sl, int cnt, logic [31:0] tg);
        cmd_t c;
        c.op = op;
        c.slot = sl[3:0];
        c.count = cnt[15:0];
        c.tag = tg;
        return c;
    endfunction

    // input handshake seen at the rising edge
    always @(posedge aclk) begin
        in_fire <= s_tvalid && s_tready;
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fire) begin
                pool_apply(s_tdata[53:0]);
                void'(cmd_queue.pop_front());
            end
            if (!s_tvalid || in_fire) begin
                if (cmd_queue.size() > 0 && !hold_sender
                        && (sender_quiet || $urandom_range(99) >= 12)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, cmd_queue[0]};
                end else begin
                    s_tvalid <= 1'b0;
                    s_tdata <= 56'({$urandom, $urandom});
                end
            end
            m_tready <= recv_quiet || $urandom_range(99) >= 12;
        end
    end

    // monitor
    always @(posedge aclk) begin
        word_t exp_w;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_queue.size() == 0) begin
                $error("unexpected word: status %0d slot %0d", m_tdata[2:0], m_tdata[6:3]);
                errors++;
            end else begin
                exp_w = result_queue.pop_front();
                if (m_tdata[2:0] != exp_w.status) begin
                    $error("status: expected %0d, got %0d", exp_w.status, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[6:3] != exp_w.slot) begin
                    $error("slot_out: expected %0d, got %0d", exp_w.slot, m_tdata[6:3]);
                    errors++;
                end
                if (m_tdata[38:7] != exp_w.tag) begin
                    $error("tag_out: expected %h, got %h", exp_w.tag, m_tdata[38:7]);
                    errors++;
                end
                if (m_tlast != exp_w.last) begin
                    $error("last: expected %0d, got %0d", exp_w.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("one_shot_timer_pool_unit: mismatch");
            $finish;
        end
    end

    function automatic cmd_t rand_cmd();
        int r;
        int cnt;
        r = $urandom_range(99);
        cnt = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(6);
        if (r < 35) return mkcmd(ostp_pkg::OP_ALLOC, $urandom_range(15), cnt, $urandom);
        if (r < 70) return mkcmd(ostp_pkg::OP_TICK, $urandom_range(15), $urandom, $urandom);
        if (r < 80) return mkcmd(ostp_pkg::OP_RECOUNT, $urandom_range(15), cnt, $urandom);
        return mkcmd(ostp_pkg::OP_FREE, $urandom_range(15), $urandom, $urandom);
    endfunction

    initial begin
        pool_clear();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: allocate, recount, tick, free, bad recount and free ops
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_ALLOC, 0, 0, 32'hFFFF_FFFF));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_ALLOC, 15, 1, 32'h0));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_ALLOC, 0, 65535, 32'h8000_0001));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_ALLOC, 0, 2, 32'h5555_AAAA));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_RECOUNT, 2, 1, 32'h0));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_RECOUNT, 9, 3, 32'h0));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_FREE, 0, 0, 32'h0));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_TICK, 0, 0, 32'h0));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_FREE, 0, 0, 32'h0));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_FREE, 2, 0, 32'h0));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_FREE, 2, 0, 32'h0));
        for (int i = 0; i < 13; i++)
            cmd_queue.push_back(mkcmd(ostp_pkg::OP_ALLOC, i, i % 3, $urandom));
        cmd_queue.push_back(mkcmd(ostp_pkg::OP_TICK, 15, 65535, 32'hFFFF_FFFF));

        wait (cmd_queue.size() == 0);
        hold_sender = 1'b1;
        wait (result_queue.size() == 0);
        hold_sender = 1'b0;

        sender_quiet = 1'b1;
        recv_quiet = 1'b1;
        for (int i = 0; i < 60; i++) cmd_queue.push_back(rand_cmd());
        wait (cmd_queue.size() == 0);
        sender_quiet = 1'b0;
        recv_quiet = 1'b0;
        for (int i = 0; i < 190; i++) cmd_queue.push_back(rand_cmd());
        for (int i = 0; i < 6; i++) cmd_queue.push_back(mkcmd(ostp_pkg::OP_TICK, 0, 0, 32'h0));
        wait (cmd_queue.size() == 0);
        wait (result_queue.size() == 0);
        repeat (40) @(posedge aclk);
        if (errors == 0 && result_queue.size() == 0) begin
            $display("one_shot_timer_pool_unit: match");
        end else begin
            $display("one_shot_timer_pool_unit: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/core/ostp_pkg.sv
rtl/core/ostp_cell.sv
rtl/core/one_shot_timer_pool_unit.sv
tb/tb_one_shot_timer_pool_unit.sv
